FILE: hw/rtl/hcf_pkg.sv
// Shared types, codes and constants of the host command framer.
// Used by every module of the block.
package hcf_pkg;

  localparam int unsigned SDRAM_BYTES_DEFAULT     = 67108864;
  localparam int unsigned DEFAULT_SAVE_AT_DEFAULT = 66846720;
  localparam int unsigned QUEUE_DEPTH_DEFAULT     = 4;

  // input operations
  localparam logic [1:0] OP_HOST = 2'd0;
  localparam logic [1:0] OP_DONE = 2'd1;
  localparam logic [1:0] OP_CPU  = 2'd2;

  // result kinds
  localparam logic [1:0] RES_BYTE  = 2'd0;
  localparam logic [1:0] RES_DMA   = 2'd1;
  localparam logic [1:0] RES_REPLY = 2'd2;

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_W = 8'h57;
  localparam logic [7:0] CHAR_Q = 8'h51;

  // configuration item selectors
  localparam logic [31:0] SEL_SDRAM    = 32'd0;
  localparam logic [31:0] SEL_WRITABLE = 32'd1;
  localparam logic [31:0] SEL_DD       = 32'd2;
  localparam logic [31:0] SEL_SAVE     = 32'd3;
  localparam logic [31:0] SEL_CIC      = 32'd4;
  localparam logic [31:0] SEL_TV       = 32'd5;

  // save types
  localparam logic [7:0] SAVE_NONE      = 8'd0;
  localparam logic [7:0] SAVE_EEP_4K    = 8'd1;
  localparam logic [7:0] SAVE_EEP_16K   = 8'd2;
  localparam logic [7:0] SAVE_SRAM      = 8'd3;
  localparam logic [7:0] SAVE_FLASH     = 8'd4;
  localparam logic [7:0] SAVE_SRAM_BANK = 8'd5;
  localparam logic [7:0] SAVE_FLASH_ALT = 8'd6;

  localparam logic [31:0] FLASH_ALT_OFFSET = 32'h0160_8000;

  localparam int unsigned FLAG_SRAM_BIT   = 3;
  localparam int unsigned FLAG_BANKED_BIT = 4;
  localparam int unsigned FLAG_FLASH_BIT  = 5;

  typedef enum logic [1:0] {
    JOB_DMA,
    JOB_REPLY,
    JOB_TRAILER,
    JOB_QUERY
  } job_kind_t;

  // one unit of work for the back end; word_a and word_b depend on kind
  typedef struct packed {
    job_kind_t   kind;
    logic        err;
    logic        dma_write;
    logic [7:0]  command;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [5:0]  flags;
    logic [31:0] save_addr;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

  typedef struct packed {
    logic [5:0]  flags;
    logic [2:0]  save_kind;
    logic [15:0] cic_kind;
    logic [7:0]  tv_kind;
    logic [31:0] save_addr;
  } cfg_state_t;

  function automatic logic [7:0] token_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CHAR_C;
      2'd1:    ch = CHAR_M;
      default: ch = CHAR_D;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/hcf_ifs.sv
// Channel interfaces of the host command framer: input items, results
// and the configuration write channel. Depends on nothing.
interface hcf_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  rx_byte;
  logic [7:0]  req_cmd;
  logic [31:0] req_arg0;
  logic [31:0] req_arg1;

  modport source (output valid, operation, rx_byte, req_cmd, req_arg0, req_arg1,
                  input ready);
  modport sink (input valid, operation, rx_byte, req_cmd, req_arg0, req_arg1,
                output ready);
endinterface

interface hcf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] dma_addr;
  logic [31:0] dma_len;
  logic        dma_write;
  logic [31:0] reply_word0;
  logic [31:0] reply_word1;
  logic [5:0]  flags_now;
  logic [31:0] save_offset_now;

  modport source (output valid, kind, tx_byte, last, dma_addr, dma_len, dma_write,
                  reply_word0, reply_word1, flags_now, save_offset_now,
                  input ready);
  modport sink (input valid, kind, tx_byte, last, dma_addr, dma_len, dma_write,
                reply_word0, reply_word1, flags_now, save_offset_now,
                output ready);
endinterface

interface hcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/hcf_front.sv
// Front end: accepts requests, tracks framing and configuration state,
// and posts a job for each request that yields results. Uses hcf_pkg.
module hcf_front import hcf_pkg::*; #(
  parameter int unsigned SDRAM_BYTES     = SDRAM_BYTES_DEFAULT,
  parameter int unsigned DEFAULT_SAVE_AT = DEFAULT_SAVE_AT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  hcf_cfg_if.sink       cfg,
  hcf_item_if.sink      item,
  input  logic          full,
  output job_slot_t     push
);

  localparam logic [31:0] DefaultOff = 32'(DEFAULT_SAVE_AT);
  localparam logic [31:0] Off512     = 32'(SDRAM_BYTES - 512);
  localparam logic [31:0] Off2k      = 32'(SDRAM_BYTES - 2048);
  localparam logic [31:0] Off32k     = 32'(SDRAM_BYTES - 32 * 1024);
  localparam logic [31:0] Off256k    = 32'(SDRAM_BYTES - 256 * 1024);
  localparam logic [31:0] Off96k     = 32'(SDRAM_BYTES - 3 * 32 * 1024);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ARGS,
    PH_WAIT
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  command, command_next;
  logic [31:0] first_arg, first_arg_next;
  logic [31:0] second_arg, second_arg_next;
  logic [31:0] disk_offset;
  cfg_state_t  cfg_st, cfg_next;
  logic        accept;

  function automatic cfg_state_t cfg_update(input cfg_state_t c, input logic [31:0] sel,
                                            input logic [31:0] val);
    cfg_state_t r;
    logic [5:0] f;
    r = c;
    f = c.flags;
    f[FLAG_SRAM_BIT]   = 1'b0;
    f[FLAG_BANKED_BIT] = 1'b0;
    f[FLAG_FLASH_BIT]  = 1'b0;
    unique case (sel) inside
      SEL_SDRAM, SEL_WRITABLE, SEL_DD: r.flags[sel[1:0]] = (val != 32'd0);
      SEL_SAVE: begin
        r.flags = f;
        if (val[7:0] <= SAVE_FLASH_ALT) begin
          r.save_kind = val[2:0];
        end
        case (val[7:0])
          SAVE_NONE:    r.save_addr = DefaultOff;
          SAVE_EEP_4K:  r.save_addr = Off512;
          SAVE_EEP_16K: r.save_addr = Off2k;
          SAVE_SRAM: begin
            r.save_addr = Off32k;
            r.flags[FLAG_SRAM_BIT] = 1'b1;
          end
          SAVE_FLASH: begin
            r.save_addr = Off256k;
            r.flags[FLAG_FLASH_BIT] = 1'b1;
          end
          SAVE_SRAM_BANK: begin
            r.save_addr = Off96k;
            r.flags[FLAG_SRAM_BIT]   = 1'b1;
            r.flags[FLAG_BANKED_BIT] = 1'b1;
          end
          SAVE_FLASH_ALT: begin
            r.save_addr = FLASH_ALT_OFFSET;
            r.flags[FLAG_FLASH_BIT] = 1'b1;
          end
          default: ;
        endcase
      end
      SEL_CIC: r.cic_kind = val[15:0];
      SEL_TV:  r.tv_kind  = val[7:0];
      default: ;
    endcase
    return r;
  endfunction

  assign item.ready = !full;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && !full;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    command_next    = command;
    first_arg_next  = first_arg;
    second_arg_next = second_arg;
    cfg_next        = cfg_st;
    push            = '0;
    push.job.kind   = JOB_TRAILER;

    if (accept) begin
      unique case (item.operation)
        OP_HOST: begin
          unique case (phase)
            PH_HUNT: begin
              if (byte_count >= 4'd3) begin
                command_next    = item.rx_byte;
                first_arg_next  = '0;
                second_arg_next = '0;
                byte_count_next = '0;
                phase_next      = PH_ARGS;
              end else if (item.rx_byte != token_char(byte_count[1:0])) begin
                // restart the match; this byte is not retried as the first char
                byte_count_next = '0;
              end else begin
                byte_count_next = byte_count + 4'd1;
              end
            end
            PH_ARGS: begin
              if (!byte_count[2]) begin
                first_arg_next = {first_arg[23:0], item.rx_byte};
              end else begin
                second_arg_next = {second_arg[23:0], item.rx_byte};
              end
              byte_count_next = byte_count + 4'd1;
              if (byte_count == 4'd7) begin
                byte_count_next  = '0;
                push.valid       = 1'b1;
                push.job.command = command;
                if (command == CHAR_R || command == CHAR_W) begin
                  phase_next         = PH_WAIT;
                  push.job.kind      = JOB_DMA;
                  push.job.dma_write = (command == CHAR_W);
                  push.job.word_a    = first_arg;
                  push.job.word_b    = second_arg_next;
                end else begin
                  phase_next = PH_HUNT;
                  if (command == CHAR_C) begin
                    cfg_next = cfg_update(cfg_st, first_arg, second_arg_next);
                  end else if (command == CHAR_Q) begin
                    push.job.kind   = JOB_QUERY;
                    push.job.word_a = {cfg_st.cic_kind, 2'b00, cfg_st.tv_kind[1:0], 1'b0,
                                       cfg_st.save_kind, 2'b00, cfg_st.flags};
                    push.job.word_b = disk_offset;
                  end else begin
                    push.job.err = 1'b1;
                  end
                end
              end
            end
            PH_WAIT: ;
            default: begin
              phase_next      = PH_HUNT;
              byte_count_next = '0;
            end
          endcase
        end
        OP_DONE: begin
          if (phase == PH_WAIT) begin
            phase_next       = PH_HUNT;
            byte_count_next  = '0;
            push.valid       = 1'b1;
            push.job.command = command;
          end else if (phase != PH_HUNT && phase != PH_ARGS) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end
        end
        OP_CPU: begin
          push.valid    = 1'b1;
          push.job.kind = JOB_REPLY;
          if (item.req_cmd == CHAR_C) begin
            cfg_next        = cfg_update(cfg_st, item.req_arg0, item.req_arg1);
            push.job.word_a = {21'd0, cfg_next.save_kind, 5'd0, cfg_next.flags[2:0]};
            push.job.word_b = {8'd0, cfg_next.tv_kind, cfg_next.cic_kind};
          end else begin
            push.job.word_a = '1;
            push.job.word_b = '1;
          end
        end
        default: ;
      endcase
    end
    push.job.flags     = cfg_next.flags;
    push.job.save_addr = cfg_next.save_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_HUNT;
      byte_count            <= '0;
      command               <= '0;
      first_arg             <= '0;
      second_arg            <= '0;
      disk_offset           <= '0;
      cfg_st.flags          <= '0;
      cfg_st.save_kind      <= '0;
      cfg_st.cic_kind       <= 16'hFFFF;
      cfg_st.tv_kind        <= 8'hFF;
      cfg_st.save_addr      <= DefaultOff;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      command    <= command_next;
      first_arg  <= first_arg_next;
      second_arg <= second_arg_next;
      cfg_st     <= cfg_next;
      if (cfg.valid) begin
        disk_offset <= cfg.data;
      end
    end
  end

endmodule

FILE: hw/rtl/hcf_queue.sv
// Job queue between front and back end: a small first-in first-out
// buffer of job_t with the head shown ahead. Uses hcf_pkg.
module hcf_queue import hcf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  job_slot_t push,
  input  logic      pop,
  output job_slot_t head,
  output logic      full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CntW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hcf_back.sv
// Back end: expands the queue head job into registered results, one per
// cycle unless the sink stalls. Uses hcf_pkg and hcf_result_if.
module hcf_back import hcf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  job_slot_t     head,
  output logic          pop,
  hcf_result_if.source  result
);

  logic        out_valid;
  logic [3:0]  idx;
  logic        step;
  logic        is_last;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic [7:0]  trailer_byte;
  logic [7:0]  query_byte;
  job_t        j;

  assign j       = head.job;
  assign step    = head.valid && (!out_valid || result.ready);
  assign pop     = step && is_last;
  assign result.valid = out_valid;

  always_comb begin
    unique case (j.kind)
      JOB_TRAILER: is_last = (idx == 4'd3);
      JOB_QUERY:   is_last = (idx == 4'd15);
      default:     is_last = 1'b1;
    endcase
  end

  // trailer position is idx mod 4, also after the twelve query bytes
  always_comb begin
    case (idx[1:0])
      2'd0:    trailer_byte = j.err ? CHAR_E : CHAR_C;
      2'd1:    trailer_byte = j.err ? CHAR_R : CHAR_M;
      2'd2:    trailer_byte = j.err ? CHAR_R : CHAR_P;
      default: trailer_byte = j.command;
    endcase
  end

  always_comb begin
    case (idx)
      4'd0:    query_byte = j.word_a[31:24];
      4'd1:    query_byte = j.word_a[23:16];
      4'd2:    query_byte = j.word_a[15:8];
      4'd3:    query_byte = j.word_a[7:0];
      4'd4:    query_byte = j.save_addr[31:24];
      4'd5:    query_byte = j.save_addr[23:16];
      4'd6:    query_byte = j.save_addr[15:8];
      4'd7:    query_byte = j.save_addr[7:0];
      4'd8:    query_byte = j.word_b[31:24];
      4'd9:    query_byte = j.word_b[23:16];
      4'd10:   query_byte = j.word_b[15:8];
      4'd11:   query_byte = j.word_b[7:0];
      default: query_byte = trailer_byte;
    endcase
  end

  always_comb begin
    unique case (j.kind)
      JOB_DMA:   r_kind = RES_DMA;
      JOB_REPLY: r_kind = RES_REPLY;
      default:   r_kind = RES_BYTE;
    endcase
    unique case (j.kind)
      JOB_TRAILER: r_byte = trailer_byte;
      JOB_QUERY:   r_byte = query_byte;
      default:     r_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (step) begin
      out_valid <= 1'b1;
      idx       <= is_last ? '0 : idx + 4'd1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.kind            <= r_kind;
      result.tx_byte         <= r_byte;
      result.last            <= is_last;
      result.dma_addr        <= (j.kind == JOB_DMA) ? j.word_a : '0;
      result.dma_len         <= (j.kind == JOB_DMA) ? j.word_b : '0;
      result.dma_write       <= (j.kind == JOB_DMA) && j.dma_write;
      result.reply_word0     <= (j.kind == JOB_REPLY) ? j.word_a : '0;
      result.reply_word1     <= (j.kind == JOB_REPLY) ? j.word_b : '0;
      result.flags_now       <= j.flags;
      result.save_offset_now <= j.save_addr;
    end
  end

endmodule

FILE: hw/rtl/host_command_framer.sv
// Host command framer. Requests are taken at one per cycle whenever the
// internal job queue (QUEUE_DEPTH entries) has room; framing and
// configuration updates finish in the cycle a request is accepted. Results
// leave through a registered output at one per cycle while the sink is
// ready: a DMA start or CPU reply is one result, a command trailer four, a
// query sixteen, so the output port sets the sustained rate and the queue
// absorbs bursts. The disk offset write channel is always ready.
module host_command_framer import hcf_pkg::*; #(
  parameter int unsigned SDRAM_BYTES     = SDRAM_BYTES_DEFAULT,
  parameter int unsigned DEFAULT_SAVE_AT = DEFAULT_SAVE_AT_DEFAULT,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  hcf_cfg_if.sink       cfg,
  hcf_item_if.sink      item,
  hcf_result_if.source  result
);

  job_slot_t push;
  job_slot_t head;
  logic      pop;
  logic      full;

  hcf_front #(
    .SDRAM_BYTES     (SDRAM_BYTES),
    .DEFAULT_SAVE_AT (DEFAULT_SAVE_AT)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .full (full),
    .push (push)
  );

  hcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  hcf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("job posted into a full queue");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.kind == RES_DMA || result.kind == RES_REPLY)) |-> result.last)
    else $error("DMA start or CPU reply not marked last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
